FILE: hw/rtl/kvs_pkg.sv
// shared types and constants for the keyframe vector sampler
`timescale 1ns / 1ps
`default_nettype none

package kvs_pkg;

  localparam int KEYS        = 64;
  localparam int ADDR_W      = $clog2(KEYS);
  localparam int CNT_W       = $clog2(KEYS + 1);
  localparam int SEG_W       = 6;
  localparam int COUNT_W     = 7;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int FRAC_W      = 16;

  localparam logic ACT_WRITE  = 1'b0;
  localparam logic ACT_SAMPLE = 1'b1;

  typedef enum logic [2:0] {
    ST_INTERP = 3'd0,
    ST_SINGLE = 3'd1,
    ST_PAST   = 3'd2,
    ST_EMPTY  = 3'd3,
    ST_WRITE  = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    OP_WRITE,
    OP_DROP,
    OP_EMPTY,
    OP_SINGLE,
    OP_SEARCH
  } op_e;

  typedef struct packed {
    logic               action;
    logic [5:0]         key_index;
    logic [31:0]        time_req;
    logic signed [31:0] value_x;
    logic signed [31:0] value_y;
    logic signed [31:0] value_z;
  } req_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic [SEG_W-1:0]   segment;
    status_e            status;
  } res_t;

  typedef struct packed {
    op_e              op;
    logic [CNT_W-1:0] n;
    req_t             req;
  } entry_t;

  typedef struct packed {
    logic   valid;
    entry_t entry;
  } cmd_t;

endpackage

`default_nettype wire

FILE: hw/rtl/kvs_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps
`default_nettype none

module kvs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

FILE: hw/rtl/kvs_front.sv
// front end: request intake, classification, key count and request queue
`timescale 1ns / 1ps
`default_nettype none

module kvs_front (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  output logic                              busy_o,
  input  wire kvs_pkg::req_t                req_i,
  input  wire logic                         cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire logic [kvs_pkg::COUNT_W-1:0]  cfg_data_i,
  input  wire logic                         pop_i,
  output kvs_pkg::cmd_t                     cmd_o
);

  logic [kvs_pkg::COUNT_W-1:0] key_count_q;
  logic [kvs_pkg::CNT_W-1:0]   n_sat;
  kvs_pkg::op_e                op;
  kvs_pkg::entry_t             entry_q [kvs_pkg::QUEUE_DEPTH];
  logic [kvs_pkg::QPTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [kvs_pkg::QCNT_W-1:0]  count_q;
  logic                        push;

  assign cfg_ready_o = 1'b1;

  // clamp the key count to the table size
  assign n_sat = (32'(key_count_q) > kvs_pkg::KEYS) ? kvs_pkg::CNT_W'(kvs_pkg::KEYS)
                                                     : kvs_pkg::CNT_W'(key_count_q);

  always_comb begin
    if (req_i.action == kvs_pkg::ACT_WRITE) begin
      op = (32'(req_i.key_index) < kvs_pkg::KEYS) ? kvs_pkg::OP_WRITE : kvs_pkg::OP_DROP;
    end else if (n_sat == '0) begin
      op = kvs_pkg::OP_EMPTY;
    end else if (n_sat == kvs_pkg::CNT_W'(1)) begin
      op = kvs_pkg::OP_SINGLE;
    end else begin
      op = kvs_pkg::OP_SEARCH;
    end
  end

  assign busy_o      = (count_q == kvs_pkg::QCNT_W'(kvs_pkg::QUEUE_DEPTH));
  assign push        = start_i && !busy_o;
  assign cmd_o.valid = (count_q != '0);
  assign cmd_o.entry = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_count_q <= '0;
      wr_ptr_q    <= '0;
      rd_ptr_q    <= '0;
      count_q     <= '0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        key_count_q <= cfg_data_i;
      end
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == kvs_pkg::QPTR_W'(kvs_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                            : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == kvs_pkg::QPTR_W'(kvs_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                            : rd_ptr_q + 1'b1;
      end
      case ({push, pop_i})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= '{op: op, n: n_sat, req: req_i};
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/kvs_back.sv
// back end: key table, segment search, factor division and interpolation
`timescale 1ns / 1ps
`default_nettype none

module kvs_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire kvs_pkg::cmd_t cmd_i,
  output logic               pop_o,
  output logic               res_valid_o,
  output kvs_pkg::res_t      res_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SINGLE,
    S_CMP,
    S_LOAD0,
    S_LOAD1,
    S_DIV,
    S_MUL,
    S_ADD
  } state_e;

  state_e                     state_q;
  logic                       res_valid_q;
  kvs_pkg::res_t              res_q;

  logic [31:0]                cur_time_q;
  logic [kvs_pkg::CNT_W-1:0]  n_q;
  logic [kvs_pkg::ADDR_W-1:0] idx_q;
  logic [31:0]                t_next_q;
  logic [31:0]                rem_q;
  logic [31:0]                den_q;
  logic [kvs_pkg::FRAC_W-1:0] quo_q;
  logic [3:0]                 bit_q;
  logic [1:0]                 comp_q;
  logic [2:0][31:0]           start_q;
  logic [2:0][31:0]           end_q;
  logic [1:0][31:0]           out_q;
  logic signed [49:0]         prod_q;

  kvs_pkg::entry_t            head;
  logic                       we;
  logic [kvs_pkg::ADDR_W-1:0] waddr;
  logic [kvs_pkg::ADDR_W-1:0] times_raddr;
  logic [kvs_pkg::ADDR_W-1:0] vals_raddr;
  logic [31:0]                times_rdata;
  logic [95:0]                vals_rdata;
  logic                       found;
  logic                       more;
  logic                       early;
  logic [32:0]                rem_shift;
  logic [32:0]                rem_sub;
  logic                       ge;
  logic [31:0]                rem_next;
  logic signed [32:0]         delta;
  logic signed [49:0]         prod_d;
  logic [31:0]                sum;

  assign head  = cmd_i.entry;
  assign pop_o = (state_q == S_IDLE) && cmd_i.valid;
  assign we    = pop_o && (head.op == kvs_pkg::OP_WRITE);
  assign waddr = kvs_pkg::ADDR_W'(head.req.key_index);

  kvs_ram #(.WIDTH(32), .DEPTH(kvs_pkg::KEYS)) u_times (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (head.req.time_req),
    .raddr_i (times_raddr),
    .rdata_o (times_rdata)
  );

  kvs_ram #(.WIDTH(96), .DEPTH(kvs_pkg::KEYS)) u_values (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i ({head.req.value_x, head.req.value_y, head.req.value_z}),
    .raddr_i (vals_raddr),
    .rdata_o (vals_rdata)
  );

  assign found  = cur_time_q < times_rdata;
  assign more   = (kvs_pkg::CNT_W'(idx_q) + kvs_pkg::CNT_W'(2)) < n_q;
  assign early  = cur_time_q < times_rdata;

  always_comb begin
    case (state_q)
      S_CMP:   times_raddr = found ? idx_q : idx_q + kvs_pkg::ADDR_W'(2);
      default: times_raddr = kvs_pkg::ADDR_W'(1);
    endcase
  end

  always_comb begin
    case (state_q)
      S_CMP:   vals_raddr = idx_q;
      S_LOAD0: vals_raddr = idx_q + kvs_pkg::ADDR_W'(1);
      default: vals_raddr = '0;
    endcase
  end

  // restoring division, one quotient bit a cycle
  assign rem_shift = {rem_q, 1'b0};
  assign rem_sub   = rem_shift - {1'b0, den_q};
  assign ge        = rem_shift >= {1'b0, den_q};
  assign rem_next  = ge ? rem_sub[31:0] : rem_shift[31:0];

  assign delta  = $signed({end_q[comp_q][31], end_q[comp_q]})
                - $signed({start_q[comp_q][31], start_q[comp_q]});
  assign prod_d = delta * $signed({1'b0, quo_q});
  assign sum    = start_q[comp_q] + prod_q[47:16];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      res_valid_q <= 1'b0;
      res_q       <= '0;
    end else begin
      res_valid_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (cmd_i.valid) begin
            case (head.op)
              kvs_pkg::OP_WRITE, kvs_pkg::OP_DROP: begin
                res_valid_q <= 1'b1;
                res_q       <= '{out_x: '0, out_y: '0, out_z: '0, segment: '0,
                                 status: kvs_pkg::ST_WRITE};
              end
              kvs_pkg::OP_EMPTY: begin
                res_valid_q <= 1'b1;
                res_q       <= '{out_x: '0, out_y: '0, out_z: '0, segment: '0,
                                 status: kvs_pkg::ST_EMPTY};
              end
              kvs_pkg::OP_SINGLE: state_q <= S_SINGLE;
              kvs_pkg::OP_SEARCH: state_q <= S_CMP;
              default:            state_q <= S_IDLE;
            endcase
          end
        end
        S_SINGLE: begin
          res_valid_q <= 1'b1;
          res_q       <= '{out_x: vals_rdata[95:64], out_y: vals_rdata[63:32],
                           out_z: vals_rdata[31:0], segment: '0,
                           status: kvs_pkg::ST_SINGLE};
          state_q     <= S_IDLE;
        end
        S_CMP: begin
          if (found) begin
            state_q <= S_LOAD0;
          end else if (!more) begin
            res_valid_q <= 1'b1;
            res_q       <= '{out_x: '0, out_y: '0, out_z: '0, segment: '0,
                             status: kvs_pkg::ST_PAST};
            state_q     <= S_IDLE;
          end
        end
        S_LOAD0: state_q <= S_LOAD1;
        S_LOAD1: state_q <= S_DIV;
        S_DIV: begin
          if (bit_q == 4'd15) begin
            state_q <= S_MUL;
          end
        end
        S_MUL: state_q <= S_ADD;
        S_ADD: begin
          if (comp_q == 2'd2) begin
            res_valid_q <= 1'b1;
            res_q       <= '{out_x: out_q[0], out_y: out_q[1], out_z: sum,
                             segment: kvs_pkg::SEG_W'(idx_q),
                             status: kvs_pkg::ST_INTERP};
            state_q     <= S_IDLE;
          end else begin
            state_q <= S_MUL;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        cur_time_q <= head.req.time_req;
        n_q        <= head.n;
        idx_q      <= '0;
      end
      S_CMP: begin
        if (found) begin
          t_next_q <= times_rdata;
        end else begin
          idx_q <= idx_q + 1'b1;
        end
      end
      S_LOAD0: begin
        // a query before the start key clamps the factor to zero
        rem_q   <= early ? 32'd0 : cur_time_q - times_rdata;
        den_q   <= early ? 32'd1 : t_next_q - times_rdata;
        start_q <= {vals_rdata[31:0], vals_rdata[63:32], vals_rdata[95:64]};
        bit_q   <= '0;
      end
      S_LOAD1: begin
        end_q  <= {vals_rdata[31:0], vals_rdata[63:32], vals_rdata[95:64]};
        comp_q <= '0;
      end
      S_DIV: begin
        rem_q <= rem_next;
        quo_q <= {quo_q[kvs_pkg::FRAC_W-2:0], ge};
        bit_q <= bit_q + 1'b1;
      end
      S_MUL: prod_q <= prod_d;
      S_ADD: begin
        if (comp_q != 2'd2) begin
          out_q[comp_q[0]] <= sum;
        end
        comp_q <= comp_q + 1'b1;
      end
      default: comp_q <= comp_q;
    endcase
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

`default_nettype wire

FILE: hw/rtl/keyframe_vector_sampler.sv
// top level of the keyframe vector sampler
`timescale 1ns / 1ps
`default_nettype none

// Keyframe track of xyz vectors, sampled by linear interpolation.
// A request is taken when start is high and busy is low. action 0 writes one
// key (time and xyz) into slot key_index; action 1 samples the track at
// time_req. Every request gives exactly one result, shown on res_o for one
// cycle with res_valid_o high; the receiver cannot hold results off.
// The user must write key_count via cfg_valid_i / cfg_ready_o / cfg_data_i
// only while no request is outstanding; the block itself does not enforce it.
// cfg_ready_o is always high. Requests pass a two-entry queue into the
// execution unit, so busy rises only when that queue is full.
// Write, dropped write and no-key requests are answered straight from idle;
// a single key returns its stored value, and other samples search the keys.
// The key search reads one key time a cycle from the time table, and the
// factor comes from a divider giving one quotient bit a cycle; the three
// components share one multiplier. The execution unit takes the next request
// from the queue only once it is idle again.
// Reset empties the queue and clears key_count; the key tables are
// undefined until written.

module keyframe_vector_sampler (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start,
  output logic                             busy,
  input  wire kvs_pkg::req_t               req_i,
  output logic                             res_valid_o,
  output kvs_pkg::res_t                    res_o,
  input  wire logic                        cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire logic [kvs_pkg::COUNT_W-1:0] cfg_data_i
);

  kvs_pkg::cmd_t cmd;
  logic          pop;

  kvs_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .busy_o      (busy),
    .req_i       (req_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .pop_i       (pop),
    .cmd_o       (cmd)
  );

  kvs_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .pop_o       (pop),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

endmodule

`default_nettype wire
